### src/pid_axis_pkg.sv
// Shared constants and register codes for the PID axis controller.
package pid_axis_pkg;

    // Field widths
    localparam int GAIN_W    = 32;
    localparam int OUT_MAX_W = 15;
    localparam int SAMPLE_W  = 16;
    localparam int MEAS_W    = 32;
    localparam int SUM_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_DT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_OVER_DT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_MODE  = 3'd5;

    // Register values after reset
    localparam logic [GAIN_W-1:0]    KP_RESET      = 32'h0003_0000;
    localparam logic [GAIN_W-1:0]    KI_DT_RESET   = 32'h0000_0000;
    localparam logic [GAIN_W-1:0]    KD_RESET      = 32'h0000_0000;
    localparam logic [OUT_MAX_W-1:0] OUT_MAX_RESET = 15'h7FFF;
    localparam logic [SAMPLE_W-1:0]  OUT_MIN_RESET = 16'h8000;

    // Request kinds carried in the input user field
    localparam logic REQ_COMPUTE = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;

    // Angle wrap and rate scaling for rate mode
    localparam logic signed [SAMPLE_W-1:0] ANGLE_HALF     = 16'sd180;
    localparam logic signed [SAMPLE_W-1:0] ANGLE_HALF_NEG = -16'sd180;
    localparam logic signed [SAMPLE_W-1:0] ANGLE_FULL     = 16'sd360;
    localparam logic signed [SAMPLE_W-1:0] RATE_SCALE     = 16'sd100;

    // Magnitude limit of the integral product, 2^45 in Q16.16 (raw value 2^61)
    localparam logic [63:0] ISUM_LIMIT = 64'h2000_0000_0000_0000;

    // Saturated 32-bit sum limits
    localparam logic [SUM_W-1:0] SUM_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_NEG_MAX = 32'h8000_0000;

endpackage

### src/pid_axis_controller.sv
// PID axis controller with output clamp: top level and complete datapath.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata/s_tuser): each transfer carries a
//   reference and a measurement in s_tdata and a request kind in s_tuser.
//   A compute request yields exactly one result; a clear request zeroes the
//   integral sum and yields no result.
//   Output stream (m_tvalid/m_tready/m_tdata/m_tuser): the clamped drive value
//   in m_tdata and the clamp flag in m_tuser.
//   Configuration: cfg_we writes cfg_data into the register chosen by
//   cfg_index in the same cycle. Write only while the block is empty.
// Stages and throughput:
//   Five register stages: input, error/integral, products, sum, output.
//   A result passes through them in that order before it appears on m_tvalid.
//   One transfer is taken every cycle while s_tready is high; the throughput
//   is one item per clock, set by the error and integral update, which carries
//   the loop state from one item to the next.
// Reset and stalls:
//   rst_n clears all stages, the loop state (last error, integral sum, last
//   angle) and loads the default gains and limits. When the receiver holds
//   m_tready low, the output keeps its result and earlier stages keep filling
//   until every stage is occupied; only then does s_tready drop.
module pid_axis_controller (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] reference, [31:16] measured
    input  logic        s_tuser,   // [0] req_type
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] control
    output logic        m_tuser,   // [0] clamped
    // Configuration write port
    input  logic                                  cfg_we,
    input  logic [pid_axis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pid_axis_pkg::CFG_DW-1:0]       cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pid_axis_pkg::GAIN_W-1:0]    kp_reg;
    logic [pid_axis_pkg::GAIN_W-1:0]    ki_dt_reg;
    logic [pid_axis_pkg::GAIN_W-1:0]    kd_over_dt_reg;
    logic [pid_axis_pkg::OUT_MAX_W-1:0] out_max_reg;
    logic [pid_axis_pkg::SAMPLE_W-1:0]  out_min_reg;
    logic                               rate_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg         <= pid_axis_pkg::KP_RESET;
            ki_dt_reg      <= pid_axis_pkg::KI_DT_RESET;
            kd_over_dt_reg <= pid_axis_pkg::KD_RESET;
            out_max_reg    <= pid_axis_pkg::OUT_MAX_RESET;
            out_min_reg    <= pid_axis_pkg::OUT_MIN_RESET;
            rate_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pid_axis_pkg::CFG_KP:         kp_reg         <= cfg_data;
                pid_axis_pkg::CFG_KI_DT:      ki_dt_reg      <= cfg_data;
                pid_axis_pkg::CFG_KD_OVER_DT: kd_over_dt_reg <= cfg_data;
                pid_axis_pkg::CFG_OUT_MAX:    out_max_reg    <= cfg_data[14:0];
                pid_axis_pkg::CFG_OUT_MIN:    out_min_reg    <= cfg_data[15:0];
                pid_axis_pkg::CFG_RATE_MODE:  rate_mode_reg  <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshakes. Each stage moves on when it is empty or the next
    // stage takes its item in the same cycle.
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, m_tvalid_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic fire1;

    assign rdy4  = !m_tvalid_reg || m_tready;
    assign rdy3  = !v3_reg || rdy4;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign rdy0  = !v0_reg || rdy1;
    assign fire1 = v0_reg && rdy1;

    assign s_tready = rdy0;
    assign m_tvalid = m_tvalid_reg;

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    logic                                     clr0_reg;
    logic signed [pid_axis_pkg::SAMPLE_W-1:0] ref0_reg;
    logic signed [pid_axis_pkg::SAMPLE_W-1:0] meas0_reg;

    always_ff @(posedge clk)
    begin
        if (rdy0 && s_tvalid)
        begin
            clr0_reg  <= (s_tuser == pid_axis_pkg::REQ_CLEAR);
            ref0_reg  <= s_tdata[15:0];
            meas0_reg <= s_tdata[31:16];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: measurement select, error, integral and derivative update.
    // The loop state is updated here so that the next item sees it.
    // ------------------------------------------------------------------
    logic signed [pid_axis_pkg::SAMPLE_W-1:0] last_error_reg;
    logic signed [pid_axis_pkg::SAMPLE_W-1:0] last_angle_reg;
    logic signed [pid_axis_pkg::SUM_W-1:0]    esum_reg;

    logic signed [15:0] angle_diff;
    logic signed [15:0] angle_wrap;
    logic signed [15:0] meas_sel;
    logic signed [15:0] err;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic signed [16:0] derr;
    logic        [31:0] sum_mag;

    always_comb
    begin
        angle_diff = meas0_reg - last_angle_reg;
        if (angle_diff > pid_axis_pkg::ANGLE_HALF)
            angle_wrap = angle_diff - pid_axis_pkg::ANGLE_FULL;
        else if (angle_diff < pid_axis_pkg::ANGLE_HALF_NEG)
            angle_wrap = angle_diff + pid_axis_pkg::ANGLE_FULL;
        else
            angle_wrap = angle_diff;

        meas_sel = rate_mode_reg ? 16'(angle_wrap * pid_axis_pkg::RATE_SCALE) : meas0_reg;
        err      = ref0_reg - meas_sel;

        sum_wide = {esum_reg[31], esum_reg} + {{17{err[15]}}, err};
        if (sum_wide[32] != sum_wide[31])
            sum_sat = sum_wide[32] ? pid_axis_pkg::SUM_NEG_MAX : pid_axis_pkg::SUM_POS_MAX;
        else
            sum_sat = sum_wide[31:0];

        derr    = {err[15], err} - {last_error_reg[15], last_error_reg};
        sum_mag = sum_sat[31] ? 32'(-sum_sat) : sum_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            last_angle_reg <= '0;
            esum_reg       <= '0;
        end
        else if (fire1)
        begin
            if (clr0_reg)
            begin
                esum_reg <= '0;
            end
            else
            begin
                esum_reg       <= sum_sat;
                last_error_reg <= err;
                if (rate_mode_reg)
                    last_angle_reg <= meas0_reg;
            end
        end
    end

    logic signed [15:0] e1_reg;
    logic signed [16:0] de1_reg;
    logic        [31:0] mag1_reg;
    logic               neg1_reg;

    always_ff @(posedge clk)
    begin
        if (fire1 && !clr0_reg)
        begin
            e1_reg   <= err;
            de1_reg  <= derr;
            mag1_reg <= sum_mag;
            neg1_reg <= sum_sat[31];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three gain products
    // ------------------------------------------------------------------
    logic signed [48:0] pk_c;
    logic signed [49:0] pd_c;
    logic        [63:0] pi_c;

    assign pk_c = $signed({1'b0, kp_reg}) * e1_reg;
    assign pd_c = $signed({1'b0, kd_over_dt_reg}) * de1_reg;
    assign pi_c = ki_dt_reg * mag1_reg;

    logic signed [48:0] pk2_reg;
    logic signed [49:0] pd2_reg;
    logic        [63:0] pi2_reg;
    logic               neg2_reg;

    always_ff @(posedge clk)
    begin
        if (v1_reg && rdy2)
        begin
            pk2_reg  <= pk_c;
            pd2_reg  <= pd_c;
            pi2_reg  <= pi_c;
            neg2_reg <= neg1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: saturate the integral product and add the three terms
    // ------------------------------------------------------------------
    logic        [63:0] pi_sat;
    logic signed [63:0] pi_signed;
    logic signed [63:0] total_c;

    always_comb
    begin
        pi_sat    = (pi2_reg > pid_axis_pkg::ISUM_LIMIT) ? pid_axis_pkg::ISUM_LIMIT : pi2_reg;
        pi_signed = neg2_reg ? -$signed(pi_sat) : $signed(pi_sat);
        total_c   = 64'(pk2_reg) + 64'(pd2_reg) + pi_signed;
    end

    logic signed [63:0] total3_reg;

    always_ff @(posedge clk)
    begin
        if (v2_reg && rdy3)
            total3_reg <= total_c;
    end

    // ------------------------------------------------------------------
    // Stage 4: truncate toward zero and clamp to the limits
    // ------------------------------------------------------------------
    logic signed [47:0] quot;
    logic signed [47:0] hi_ext;
    logic signed [47:0] lo_ext;
    logic        [15:0] ctl_c;
    logic               clip_c;

    always_comb
    begin
        // Negative values with a nonzero fraction round up toward zero.
        quot   = total3_reg[63:16]
               + 48'(total3_reg[63] && (total3_reg[15:0] != 16'h0000));
        hi_ext = $signed({33'b0, out_max_reg});
        lo_ext = $signed({{32{out_min_reg[15]}}, out_min_reg});
        if (quot > hi_ext)
        begin
            ctl_c  = {1'b0, out_max_reg};
            clip_c = 1'b1;
        end
        else if (quot < lo_ext)
        begin
            ctl_c  = out_min_reg;
            clip_c = 1'b1;
        end
        else
        begin
            ctl_c  = quot[15:0];
            clip_c = 1'b0;
        end
    end

    logic [15:0] ctl_reg;
    logic        clip_reg;

    always_ff @(posedge clk)
    begin
        if (v3_reg && rdy4)
        begin
            ctl_reg  <= ctl_c;
            clip_reg <= clip_c;
        end
    end

    assign m_tdata = ctl_reg;
    assign m_tuser = clip_reg;

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= s_tvalid;
            if (rdy1)
                v1_reg <= v0_reg && !clr0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                m_tvalid_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A clear request leaves a zero integral sum behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire1 && clr0_reg) |=> (esum_reg == '0))
        else $error("integral sum not cleared by clear request");

    // A positive error never lowers the saturating integral sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire1 && !clr0_reg && !err[15] && (err != 16'sd0))
        |=> ($signed(esum_reg) >= $signed($past(esum_reg))))
        else $error("integral sum decreased on positive error");

    // Input back-pressure only when every stage holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v0_reg && v1_reg && v2_reg && v3_reg && m_tvalid_reg))
        else $error("input stalled with an empty stage");

    // The stored angle moves only on a rate-mode compute item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (last_angle_reg != $past(last_angle_reg))
        |-> $past(fire1 && !clr0_reg && rate_mode_reg))
        else $error("last angle changed outside rate mode");

endmodule
